// ===== rtl/bls_pkg.sv =====
// ---------------------------------------------------------------------------
// bls_pkg
// Shared types and codes for the bounded LIFO stack.
// ---------------------------------------------------------------------------
package bls_pkg;

    localparam int CMD_W  = 3;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 7;
    localparam int ERR_W  = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DISCARD = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_OVER  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_UNDER = 2'd2;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic take;   // word accepted this cycle
        logic load;   // move pending result into the output register
    } t_dp_ctl;

endpackage

// ===== rtl/bls_in_if.sv =====
// ---------------------------------------------------------------------------
// bls_in_if
// Command channel: valid/ready handshake with command payload.
// ---------------------------------------------------------------------------
interface bls_in_if
    import bls_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] push_data;
    logic [CNT_W-1:0]  amount;

    modport source (output valid, command, push_data, amount, input ready);
    modport sink   (input valid, command, push_data, amount, output ready);
endinterface

// ===== rtl/bls_out_if.sv =====
// ---------------------------------------------------------------------------
// bls_out_if
// Result channel: valid/ready handshake with result payload.
// ---------------------------------------------------------------------------
interface bls_out_if
    import bls_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic [CNT_W-1:0]  depth_now;
    logic [CNT_W-1:0]  space_left;
    logic [CNT_W-1:0]  high_water;
    logic [ERR_W-1:0]  error_code;

    modport source (output valid, read_data, depth_now, space_left, high_water,
                    error_code, input ready);
    modport sink   (input valid, read_data, depth_now, space_left, high_water,
                    error_code, output ready);
endinterface

// ===== rtl/bls_ram.sv =====
// ---------------------------------------------------------------------------
// bls_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bls_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/bls_ctrl.sv =====
// ---------------------------------------------------------------------------
// bls_ctrl
// Sequencer: accept a word, wait in S_READ for the registered RAM read data, hand off the result.
// ---------------------------------------------------------------------------
module bls_ctrl
    import bls_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_ctl o_ctl
);
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctl.take = 1'b0;
        o_ctl.load = 1'b0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.take = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                // output register free, or being emptied this cycle
                o_ctl.load = !r_out_valid || i_out_ready;
                if (o_ctl.load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_ctl.load | (r_out_valid & ~i_out_ready);
    end

    assign o_out_valid = r_out_valid;
endmodule

// ===== rtl/bls_dp.sv =====
// ---------------------------------------------------------------------------
// bls_dp
// Datapath: height and peak counters, capacity register, item RAM,
// pending result and output register.
// ---------------------------------------------------------------------------
module bls_dp
    import bls_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    input  t_dp_ctl           i_ctl,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [DATA_W-1:0] i_push_data,
    input  logic [CNT_W-1:0]  i_amount,
    output logic [DATA_W-1:0] o_read_data,
    output logic [CNT_W-1:0]  o_depth_now,
    output logic [CNT_W-1:0]  o_space_left,
    output logic [CNT_W-1:0]  o_high_water,
    output logic [ERR_W-1:0]  o_error_code
);
    localparam int AW  = $clog2(DEPTH);
    localparam int AXW = (AW > CNT_W) ? AW : CNT_W;
    localparam int DXW = (WIDTH > DATA_W) ? WIDTH : DATA_W;
    // largest limit reachable through a 7-bit capacity
    localparam logic [CNT_W:0] DCAP = (DEPTH > 127) ? 8'd127 : (CNT_W+1)'(DEPTH);

    logic [CNT_W-1:0] r_cap;
    logic [CNT_W-1:0] r_height, n_height;
    logic [CNT_W-1:0] r_peak, n_peak;

    // pending result, waiting for RAM read data
    logic [CNT_W-1:0] r_p_depth, r_p_space, r_p_peak;
    logic [ERR_W-1:0] r_p_err;
    logic             r_p_rd;

    // output register
    logic [DATA_W-1:0] r_o_data;
    logic [CNT_W-1:0]  r_o_depth, r_o_space, r_o_peak;
    logic [ERR_W-1:0]  r_o_err;

    logic [CNT_W-1:0] lim, space, rd_idx;
    logic [ERR_W-1:0] err;
    logic             rd_hit, wr_en;
    logic [AXW-1:0]   wr_x, rd_x;
    logic [DXW-1:0]   wdata_x, rdata_x;
    logic [WIDTH-1:0] ram_q;

    always_comb begin
        lim = ({1'b0, r_cap} > DCAP) ? DCAP[CNT_W-1:0] : r_cap;
        n_height = r_height;
        err      = ERR_OK;
        rd_hit   = 1'b0;
        wr_en    = 1'b0;
        rd_idx   = r_height - 7'd1;
        case (i_command)
            CMD_PUSH: begin
                if (r_height >= lim) begin
                    err = ERR_OVER;
                end else begin
                    wr_en    = i_ctl.take;
                    n_height = r_height + 7'd1;
                end
            end
            CMD_POP: begin
                if (r_height == '0) begin
                    err = ERR_UNDER;
                end else begin
                    rd_hit   = 1'b1;
                    n_height = r_height - 7'd1;
                end
            end
            CMD_PEEK: begin
                rd_idx = r_height - 7'd1 - i_amount;
                if (i_amount >= r_height) begin
                    err = ERR_UNDER;
                end else begin
                    rd_hit = 1'b1;
                end
            end
            CMD_DISCARD: begin
                if (i_amount > r_height) begin
                    err = ERR_UNDER;
                end else begin
                    n_height = r_height - i_amount;
                end
            end
            CMD_CLEAR: begin
                n_height = '0;
            end
            default: begin
            end
        endcase
        n_peak = (n_height > r_peak) ? n_height : r_peak;
        space  = (lim > n_height) ? (lim - n_height) : '0;
        wr_x    = AXW'(r_height);
        rd_x    = AXW'(rd_idx);
        wdata_x = DXW'(i_push_data);
        rdata_x = DXW'(ram_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CAP_RESET;
            r_height <= '0;
            r_peak   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_ctl.take) begin
                r_height <= n_height;
                r_peak   <= n_peak;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_p_depth <= n_height;
            r_p_space <= space;
            r_p_peak  <= n_peak;
            r_p_err   <= err;
            r_p_rd    <= rd_hit;
        end
        if (i_ctl.load) begin
            r_o_data  <= r_p_rd ? rdata_x[DATA_W-1:0] : '0;
            r_o_depth <= r_p_depth;
            r_o_space <= r_p_space;
            r_o_peak  <= r_p_peak;
            r_o_err   <= r_p_err;
        end
    end

    bls_ram #(
        .W (WIDTH),
        .D (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_x[AW-1:0]),
        .i_wdata (wdata_x[WIDTH-1:0]),
        .i_re    (i_ctl.take & rd_hit),
        .i_raddr (rd_x[AW-1:0]),
        .o_rdata (ram_q)
    );

    assign o_read_data  = r_o_data;
    assign o_depth_now  = r_o_depth;
    assign o_space_left = r_o_space;
    assign o_high_water = r_o_peak;
    assign o_error_code = r_o_err;
endmodule

// ===== rtl/bounded_lifo_stack.sv =====
// ---------------------------------------------------------------------------
// bounded_lifo_stack
// Bounded LIFO stack with configurable capacity and high-water mark.
// ---------------------------------------------------------------------------
// Channel    Dir  Handshake         Word
// i_cmd      in   valid/ready       command, push_data, amount
// o_res      out  valid/ready       read_data, depth_now, space_left,
//                                   high_water, error_code
// i_cfg_*    in   write enable      capacity (7 bits)
//
// Each command is handled in S_IDLE, which updates the counters and issues the
// item RAM access, then in S_READ, which takes the registered RAM read data.
// The next command is taken while the previous result waits in the output
// register; a stalled output holds the following result in the datapath.
// Reset (i_rst_n low, synchronous) empties the stack, clears the high-water
// mark and sets capacity to 64. RAM contents are not cleared.
// ---------------------------------------------------------------------------
module bounded_lifo_stack
    import bls_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    bls_in_if.sink           i_cmd,
    bls_out_if.source        o_res
);
    t_dp_ctl ctl;

    bls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_out_ready (o_res.ready),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .o_ctl       (ctl)
    );

    bls_dp #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_ctl        (ctl),
        .i_command    (i_cmd.command),
        .i_push_data  (i_cmd.push_data),
        .i_amount     (i_cmd.amount),
        .o_read_data  (o_res.read_data),
        .o_depth_now  (o_res.depth_now),
        .o_space_left (o_res.space_left),
        .o_high_water (o_res.high_water),
        .o_error_code (o_res.error_code)
    );

    // a taken word always passes through S_READ for the RAM read before the next is taken
    a_two_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("command taken on back-to-back cycles");

    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.high_water >= o_res.depth_now))
        else $error("high-water mark below current height");

    a_over_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.error_code == ERR_OVER) |-> (o_res.space_left == '0))
        else $error("overflow reported with space left");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.error_code != ERR_OK) |-> (o_res.read_data == '0))
        else $error("nonzero read data on error");
endmodule
